>>> src/skt_pkg.sv
// ----------------------------------------------------------------------------
// skt_pkg
// shared types, codes and sizes of the sorted key table
// ----------------------------------------------------------------------------
package skt_pkg;

    localparam int SKT_CAPACITY = 256;

    localparam int KEY_W   = 31;
    localparam int TAG_W   = 32;
    localparam int ENT_W   = KEY_W + TAG_W;
    localparam int POS_W   = 9;
    localparam int REQ_W   = 2;
    localparam int STAT_W  = 2;
    localparam int IN_DW   = 64;
    localparam int OUT_DW  = 56;

    typedef enum logic [REQ_W-1:0] {
        REQ_LOOKUP = 2'd0,
        REQ_INSERT = 2'd1,
        REQ_DELETE = 2'd2
    } t_req;

    typedef enum logic [STAT_W-1:0] {
        STAT_OK        = 2'd0,
        STAT_NOT_FOUND = 2'd1,
        STAT_EXISTS    = 2'd2,
        STAT_FULL      = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SRCH,
        ST_CMP,
        ST_EXEC,
        ST_SHIFT,
        ST_PUT,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic [TAG_W-1:0]  found_tag;
        logic [POS_W-1:0]  position;
        logic [POS_W-1:0]  entry_count;
    } t_result;

endpackage

>>> src/skt_ram.sv
// ----------------------------------------------------------------------------
// skt_ram
// entry store, one write port and one read port, registered read data
// ----------------------------------------------------------------------------
module skt_ram import skt_pkg::*; #(
    parameter int DEPTH = SKT_CAPACITY,
    parameter int AW    = $clog2(SKT_CAPACITY),
    parameter int DW    = ENT_W
) (
    input  logic          i_clk,
    input  logic          i_wr_en,
    input  logic [AW-1:0] i_wr_addr,
    input  logic [DW-1:0] i_wr_data,
    input  logic [AW-1:0] i_rd_addr,
    output logic [DW-1:0] o_rd_data
);

    logic [DW-1:0] r_mem [DEPTH];
    logic [DW-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

>>> src/skt_ctrl.sv
// ----------------------------------------------------------------------------
// skt_ctrl
// request sequencer: binary search, shift walk and entry write
// ----------------------------------------------------------------------------
module skt_ctrl import skt_pkg::*; #(
    parameter int CAPACITY = SKT_CAPACITY
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_vld,
    output logic                            o_in_rdy,
    input  logic [REQ_W-1:0]                i_req,
    input  logic [KEY_W-1:0]                i_key,
    input  logic [TAG_W-1:0]                i_tag,
    output logic                            o_res_vld,
    input  logic                            i_res_rdy,
    output t_result                         o_res,
    output logic [$clog2(CAPACITY)-1:0]     o_rd_addr,
    input  logic [ENT_W-1:0]                i_rd_data,
    output logic                            o_wr_en,
    output logic [$clog2(CAPACITY)-1:0]     o_wr_addr,
    output logic [ENT_W-1:0]                o_wr_data
);

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);

    t_state            r_state, n_state;
    logic [REQ_W-1:0]  r_req, n_req;
    logic [KEY_W-1:0]  r_key, n_key;
    logic [TAG_W-1:0]  r_tag, n_tag;
    logic [CW-1:0]     r_lo, n_lo;
    logic [CW-1:0]     r_hi, n_hi;
    logic [AW-1:0]     r_mid, n_mid;
    logic              r_hit, n_hit;
    logic [CW-1:0]     r_pos, n_pos;
    logic [TAG_W-1:0]  r_ftag, n_ftag;
    logic [CW-1:0]     r_count, n_count;
    logic [AW-1:0]     r_rd, n_rd;
    logic [CW-1:0]     r_rem, n_rem;
    logic              r_wb_vld, n_wb_vld;
    logic [AW-1:0]     r_wb_addr, n_wb_addr;
    logic              r_up, n_up;
    logic [STAT_W-1:0] r_status, n_status;

    logic [CW:0]       w_sum;
    logic [AW-1:0]     w_mid;
    logic [KEY_W-1:0]  w_rd_key;
    logic [TAG_W-1:0]  w_rd_tag;

    // midpoint of the inclusive range [lo, hi-1], as the search defines it
    assign w_sum    = {1'b0, r_lo} + {1'b0, r_hi} - (CW+1)'(1);
    assign w_mid    = w_sum[AW:1];
    assign w_rd_key = i_rd_data[KEY_W-1:0];
    assign w_rd_tag = i_rd_data[ENT_W-1:KEY_W];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_count  <= '0;
            r_wb_vld <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_wb_vld <= n_wb_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_req     <= n_req;
        r_key     <= n_key;
        r_tag     <= n_tag;
        r_lo      <= n_lo;
        r_hi      <= n_hi;
        r_mid     <= n_mid;
        r_hit     <= n_hit;
        r_pos     <= n_pos;
        r_ftag    <= n_ftag;
        r_rd      <= n_rd;
        r_rem     <= n_rem;
        r_wb_addr <= n_wb_addr;
        r_up      <= n_up;
        r_status  <= n_status;
    end

    always_comb begin
        n_state   = r_state;
        n_req     = r_req;
        n_key     = r_key;
        n_tag     = r_tag;
        n_lo      = r_lo;
        n_hi      = r_hi;
        n_mid     = r_mid;
        n_hit     = r_hit;
        n_pos     = r_pos;
        n_ftag    = r_ftag;
        n_count   = r_count;
        n_rd      = r_rd;
        n_rem     = r_rem;
        n_wb_vld  = r_wb_vld;
        n_wb_addr = r_wb_addr;
        n_up      = r_up;
        n_status  = r_status;
        o_in_rdy  = 1'b0;
        o_res_vld = 1'b0;
        o_rd_addr = '0;
        o_wr_en   = 1'b0;
        o_wr_addr = r_wb_addr;
        o_wr_data = i_rd_data;

        case (r_state)
            ST_IDLE: begin
                o_in_rdy = 1'b1;
                if (i_in_vld) begin
                    n_req   = i_req;
                    n_key   = i_key;
                    n_tag   = i_tag;
                    n_lo    = '0;
                    n_hi    = r_count;
                    n_hit   = 1'b0;
                    n_ftag  = '0;
                    n_state = ST_SRCH;
                end
            end
            ST_SRCH: begin
                if (r_lo < r_hi) begin
                    o_rd_addr = w_mid;
                    n_mid     = w_mid;
                    n_state   = ST_CMP;
                end else begin
                    n_pos   = r_lo;
                    n_state = ST_EXEC;
                end
            end
            ST_CMP: begin
                if (w_rd_key > r_key) begin
                    n_hi    = CW'(r_mid);
                    n_state = ST_SRCH;
                end else if (w_rd_key < r_key) begin
                    n_lo    = CW'(r_mid) + CW'(1);
                    n_state = ST_SRCH;
                end else begin
                    n_hit   = 1'b1;
                    n_pos   = CW'(r_mid);
                    n_ftag  = w_rd_tag;
                    n_state = ST_EXEC;
                end
            end
            ST_EXEC: begin
                n_wb_vld = 1'b0;
                case (r_req)
                    REQ_INSERT: begin
                        n_ftag = '0;
                        if (r_hit) begin
                            n_status = STAT_EXISTS;
                            n_state  = ST_DONE;
                        end else if (r_count == CW'(CAPACITY)) begin
                            n_status = STAT_FULL;
                            n_state  = ST_DONE;
                        end else begin
                            n_status = STAT_OK;
                            n_up     = 1'b1;
                            n_rd     = AW'(r_count - CW'(1));
                            n_rem    = r_count - r_pos;
                            n_state  = ST_SHIFT;
                        end
                    end
                    REQ_DELETE: begin
                        n_ftag = '0;
                        if (r_hit) begin
                            n_status = STAT_OK;
                            n_up     = 1'b0;
                            n_rd     = AW'(r_pos + CW'(1));
                            n_rem    = r_count - r_pos - CW'(1);
                            n_state  = ST_SHIFT;
                        end else begin
                            n_status = STAT_NOT_FOUND;
                            n_state  = ST_DONE;
                        end
                    end
                    default: begin
                        n_status = r_hit ? STAT_OK : STAT_NOT_FOUND;
                        n_state  = ST_DONE;
                    end
                endcase
            end
            ST_SHIFT: begin
                // read one entry ahead, write it back one slot over in the next cycle
                if (r_wb_vld) begin
                    o_wr_en = 1'b1;
                end
                if (r_rem != '0) begin
                    o_rd_addr = r_rd;
                    n_wb_vld  = 1'b1;
                    n_wb_addr = r_up ? r_rd + AW'(1) : r_rd - AW'(1);
                    n_rd      = r_up ? r_rd - AW'(1) : r_rd + AW'(1);
                    n_rem     = r_rem - CW'(1);
                end else begin
                    n_wb_vld = 1'b0;
                    if (!r_wb_vld) begin
                        if (r_up) begin
                            n_state = ST_PUT;
                        end else begin
                            n_count = r_count - CW'(1);
                            n_state = ST_DONE;
                        end
                    end
                end
            end
            ST_PUT: begin
                o_wr_en   = 1'b1;
                o_wr_addr = AW'(r_pos);
                o_wr_data = {r_tag, r_key};
                n_count   = r_count + CW'(1);
                n_state   = ST_DONE;
            end
            ST_DONE: begin
                o_res_vld = 1'b1;
                if (i_res_rdy) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign o_res.status      = r_status;
    assign o_res.found_tag   = r_ftag;
    assign o_res.position    = POS_W'(r_pos);
    assign o_res.entry_count = POS_W'(r_count);

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(CAPACITY))
        else $error("entry count beyond capacity");

    a_full_only_at_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_vld && r_status == STAT_FULL) |-> (r_count == CW'(CAPACITY)))
        else $error("table full reported below capacity");

    a_put_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_PUT) |=> (r_count == $past(r_count) + CW'(1)))
        else $error("insert did not grow the table");

    a_tag_on_hit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_vld && r_status != STAT_OK) |-> (r_ftag == '0))
        else $error("tag returned without a hit");

endmodule

>>> src/sorted_key_table.sv
// ----------------------------------------------------------------------------
// sorted_key_table
// sorted key/tag table with lookup, insert and delete by binary search
// ----------------------------------------------------------------------------
// The table keeps up to CAPACITY entries in ascending key order in one
// synchronous RAM of {name_tag, key} words. Each request runs a binary search
// over the valid entries, each probe a RAM read and then a compare, with at
// most ceil(log2(count+1)) probes and a last bounds check to close a search
// that misses. An insert then walks the entries from the insertion point up
// by one slot and a delete walks the ones above the hit down, one entry per
// cycle through the single read and write ports, writing the last entry before
// it leaves the walk; an insert then writes the new entry. One request is in
// work at a time; the finished result sits in an output register so the next
// request is taken while the result waits for the downstream side. No clearing
// pass is needed after reset: only entries below the count are ever read.
// ----------------------------------------------------------------------------
module sorted_key_table import skt_pkg::*; #(
    parameter int CAPACITY = SKT_CAPACITY
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    // request stream
    input  logic              s_axis_tvalid,
    output logic              s_axis_tready,
    input  logic [IN_DW-1:0]  s_axis_tdata,   // key[30:0], name_tag[62:31], zero pad
    input  logic [REQ_W-1:0]  s_axis_tuser,   // req_type[1:0]
    // result stream
    output logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    output logic [OUT_DW-1:0] m_axis_tdata    // status[1:0], found_tag[33:2],
                                              // position[42:34], entry_count[51:43],
                                              // zero pad
);

    localparam int AW = $clog2(CAPACITY);

    logic           w_res_vld;
    logic           w_res_rdy;
    t_result        w_res;
    logic [AW-1:0]  w_rd_addr;
    logic [ENT_W-1:0] w_rd_data;
    logic           w_wr_en;
    logic [AW-1:0]  w_wr_addr;
    logic [ENT_W-1:0] w_wr_data;

    // output register: one result may wait here while the next request runs
    logic              r_out_vld, n_out_vld;
    logic [OUT_DW-1:0] r_out_data, n_out_data;

    skt_ctrl #(
        .CAPACITY (CAPACITY)
    ) u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in_vld  (s_axis_tvalid),
        .o_in_rdy  (s_axis_tready),
        .i_req     (s_axis_tuser),
        .i_key     (s_axis_tdata[KEY_W-1:0]),
        .i_tag     (s_axis_tdata[ENT_W-1:KEY_W]),
        .o_res_vld (w_res_vld),
        .i_res_rdy (w_res_rdy),
        .o_res     (w_res),
        .o_rd_addr (w_rd_addr),
        .i_rd_data (w_rd_data),
        .o_wr_en   (w_wr_en),
        .o_wr_addr (w_wr_addr),
        .o_wr_data (w_wr_data)
    );

    skt_ram #(
        .DEPTH (CAPACITY),
        .AW    (AW),
        .DW    (ENT_W)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (w_wr_addr),
        .i_wr_data (w_wr_data),
        .i_rd_addr (w_rd_addr),
        .o_rd_data (w_rd_data)
    );

    // the register takes a new result when empty or when its transfer completes
    assign w_res_rdy = !r_out_vld || m_axis_tready;

    always_comb begin
        n_out_vld  = r_out_vld;
        n_out_data = r_out_data;
        if (w_res_rdy) begin
            n_out_vld = w_res_vld;
            if (w_res_vld) begin
                n_out_data = {(OUT_DW - STAT_W - TAG_W - 2*POS_W)'(0),
                              w_res.entry_count, w_res.position,
                              w_res.found_tag, w_res.status};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else begin
            r_out_vld <= n_out_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_data <= n_out_data;
    end

    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = r_out_data;

endmodule

>>> tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the sorted key table
// ----------------------------------------------------------------------------
// Requests go in on the slave stream and results come back on the master
// stream. A mirror of the table (keys, tags and entry count) is updated at
// every accepted request and yields the result that the block must return;
// results are compared field by field in arrival order. The run covers a
// short directed set, a fill to capacity and back down to empty, a long
// receiver hold-off, and a random mix that swings the table between nearly
// empty and full. Both stream sides idle and stall at random.
// ----------------------------------------------------------------------------
module tb;
    import skt_pkg::*;

    // request code that the block treats as a lookup
    localparam logic [REQ_W-1:0] REQ_SPARE = 2'd3;
    localparam logic [KEY_W-1:0] KEY_TOP   = '1;
    localparam logic [TAG_W-1:0] TAG_TOP   = '1;
    localparam int POOL_SIZE   = 320;
    localparam int DRAIN_LIMIT = 100000;
    // longest request: full shift plus the search and write cycles
    localparam int SETTLE_CYCLES = 320;

    logic              i_clk;
    logic              i_rst_n;
    logic              s_axis_tvalid;
    logic              s_axis_tready;
    logic [IN_DW-1:0]  s_axis_tdata;   // key[30:0], name_tag[62:31], zero pad
    logic [REQ_W-1:0]  s_axis_tuser;   // req_type[1:0]
    logic              m_axis_tvalid;
    logic              m_axis_tready;
    logic [OUT_DW-1:0] m_axis_tdata;   // status[1:0], found_tag[33:2],
                                       // position[42:34], entry_count[51:43],
                                       // zero pad

    // mirror of the table contents
    logic [KEY_W-1:0] mirror_keys [SKT_CAPACITY];
    logic [TAG_W-1:0] mirror_tags [SKT_CAPACITY];
    int               mirror_count;

    t_result          awaited_replies [$];
    logic [KEY_W-1:0] key_pool [POOL_SIZE];
    int               n_fail;
    bit               steady;        // no idling on either side
    int               hold_cycles;   // receiver hold-off request

    sorted_key_table i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // generous ceiling on the whole run
    initial begin
        #20ms;
        $display("%0t timeout, %0d results outstanding", $time, awaited_replies.size());
        $display("RESULT: ERROR");
        $finish;
    end

    // ------------------------------------------------------------------------
    // mirror of the table
    // ------------------------------------------------------------------------

    // binary search over the valid entries: match index or insertion point
    function automatic bit search_key(input logic [KEY_W-1:0] k, output int where);
        int lo;
        int hi;
        int mid;
        lo = 0;
        hi = mirror_count - 1;
        while (lo <= hi) begin
            mid = (lo + hi) / 2;
            if (mirror_keys[mid] > k) begin
                hi = mid - 1;
            end else if (mirror_keys[mid] < k) begin
                lo = mid + 1;
            end else begin
                where = mid;
                return 1'b1;
            end
        end
        where = lo;
        return 1'b0;
    endfunction

    // applies one request to the mirror and returns the reply it must give
    function automatic t_result table_apply(input logic [REQ_W-1:0] req,
                                            input logic [KEY_W-1:0] k,
                                            input logic [TAG_W-1:0] tag);
        t_result r;
        int      where;
        bit      hit;
        int      i;
        hit         = search_key(k, where);
        r.found_tag = '0;
        r.position  = where[POS_W-1:0];
        if (req == REQ_INSERT) begin
            if (hit) begin
                r.status = STAT_EXISTS;
            end else if (mirror_count >= SKT_CAPACITY) begin
                r.status = STAT_FULL;
            end else begin
                for (i = mirror_count; i > where; i--) begin
                    mirror_keys[i] = mirror_keys[i-1];
                    mirror_tags[i] = mirror_tags[i-1];
                end
                mirror_keys[where] = k;
                mirror_tags[where] = tag;
                mirror_count++;
                r.status = STAT_OK;
            end
        end else if (req == REQ_DELETE) begin
            if (hit) begin
                for (i = where + 1; i < mirror_count; i++) begin
                    mirror_keys[i-1] = mirror_keys[i];
                    mirror_tags[i-1] = mirror_tags[i];
                end
                mirror_count--;
                r.status = STAT_OK;
            end else begin
                r.status = STAT_NOT_FOUND;
            end
        end else begin
            // lookup, and the spare code behaves the same way
            if (hit) begin
                r.found_tag = mirror_tags[where];
                r.status    = STAT_OK;
            end else begin
                r.status = STAT_NOT_FOUND;
            end
        end
        r.entry_count = mirror_count[POS_W-1:0];
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // stream drivers
    // ------------------------------------------------------------------------

    // mostly no gap, often a short one, now and then a long one
    function automatic int pick_gap();
        int r;
        if (steady) return 0;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(4, 40);
    endfunction

    // one request transfer; returns at the accepting edge
    task automatic send_request(input logic [REQ_W-1:0] req,
                                input logic [KEY_W-1:0] k,
                                input logic [TAG_W-1:0] tag);
        int      gap;
        t_result want;
        gap = pick_gap();
        @(negedge i_clk);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {1'b0, tag, k};
        s_axis_tuser  <= req;
        do @(posedge i_clk); while (!s_axis_tready);
        want            = table_apply(req, k, tag);
        awaited_replies = {awaited_replies, want};
    endtask

    task automatic drop_valid();
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
    endtask

    // sender pauses until every result is back
    task automatic wait_drained();
        int n;
        drop_valid();
        n = 0;
        while (awaited_replies.size() != 0 && n < DRAIN_LIMIT) begin
            @(posedge i_clk);
            n++;
        end
        if (awaited_replies.size() != 0) begin
            $display("%0t %0d results never arrived", $time, awaited_replies.size());
            n_fail++;
            awaited_replies.delete();
        end
    endtask

    // receiver: random stalls, plus a counted hold-off when asked
    initial begin
        int  stall_left;
        logic rdy;
        stall_left    = 0;
        m_axis_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_cycles > 0) begin
                hold_cycles--;
                rdy = 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                rdy = 1'b0;
            end else begin
                rdy = 1'b1;
                if (!steady && $urandom_range(0, 3) == 0) stall_left = pick_gap();
            end
            m_axis_tready <= rdy;
        end
    end

    // result checker: each result transfer against the oldest expectation
    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (awaited_replies.size() == 0) begin
                $display("%0t unexpected result %h", $time, m_axis_tdata);
                n_fail++;
            end else begin
                want = awaited_replies.pop_front();
                if (m_axis_tdata[1:0] !== want.status) begin
                    $display("%0t status: expected %0d actual %0d",
                             $time, want.status, m_axis_tdata[1:0]);
                    n_fail++;
                end
                if (m_axis_tdata[33:2] !== want.found_tag) begin
                    $display("%0t found_tag: expected %h actual %h",
                             $time, want.found_tag, m_axis_tdata[33:2]);
                    n_fail++;
                end
                if (m_axis_tdata[42:34] !== want.position) begin
                    $display("%0t position: expected %0d actual %0d",
                             $time, want.position, m_axis_tdata[42:34]);
                    n_fail++;
                end
                if (m_axis_tdata[51:43] !== want.entry_count) begin
                    $display("%0t entry_count: expected %0d actual %0d",
                             $time, want.entry_count, m_axis_tdata[51:43]);
                    n_fail++;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------------

    // extreme keys and tags, every request code, misses, duplicates, empty table
    task automatic test_directed();
        send_request(REQ_LOOKUP, '0, TAG_TOP);
        send_request(REQ_DELETE, KEY_TOP, '0);
        send_request(REQ_INSERT, '0, '0);
        send_request(REQ_INSERT, KEY_TOP, TAG_TOP);
        send_request(REQ_INSERT, 31'h4000_0000, 32'hA5A5_A5A5);
        send_request(REQ_INSERT, '0, TAG_TOP);           // key already present
        send_request(REQ_LOOKUP, KEY_TOP, '0);
        send_request(REQ_LOOKUP, '0, TAG_TOP);
        send_request(REQ_LOOKUP, 31'd5, '0);             // miss between entries
        send_request(REQ_SPARE, KEY_TOP, '0);            // spare code, hit
        send_request(REQ_SPARE, 31'h3FFF_FFFF, TAG_TOP); // spare code, miss
        send_request(REQ_INSERT, 31'd1, 32'h5A5A_5A5A);  // shifts the upper part
        send_request(REQ_DELETE, 31'h4000_0000, '0);
        send_request(REQ_DELETE, 31'h4000_0000, '0);     // now absent
        send_request(REQ_LOOKUP, 31'd1, '0);
        send_request(REQ_DELETE, '0, TAG_TOP);
        send_request(REQ_DELETE, KEY_TOP, '0);
        send_request(REQ_DELETE, 31'd1, '0);
        send_request(REQ_SPARE, '0, '0);                 // empty again
        wait_drained();
    endtask

    // fill to capacity, hit the full and duplicate cases, empty it again
    task automatic test_fill_and_empty();
        int n;
        n = 0;
        while (mirror_count < SKT_CAPACITY) begin
            steady = (n >= 64 && n < 160);
            send_request(REQ_INSERT, KEY_W'($urandom), $urandom);
            n++;
        end
        steady = 1'b0;
        send_request(REQ_INSERT, KEY_W'($urandom), $urandom);   // full
        send_request(REQ_INSERT, mirror_keys[SKT_CAPACITY-1], $urandom);
        send_request(REQ_INSERT, mirror_keys[0], $urandom);
        send_request(REQ_LOOKUP, mirror_keys[0], '0);
        send_request(REQ_LOOKUP, mirror_keys[SKT_CAPACITY-1], '0);
        send_request(REQ_LOOKUP, KEY_TOP, '0);
        while (mirror_count > 0) begin
            send_request(REQ_DELETE, mirror_keys[$urandom_range(0, mirror_count - 1)],
                         $urandom);
        end
        wait_drained();
    endtask

    // receiver holds off long enough for the block to stall its input
    task automatic test_backpressure();
        steady = 1'b1;
        @(negedge i_clk);
        hold_cycles = 600;
        repeat (6) send_request(REQ_INSERT, KEY_W'($urandom), $urandom);
        repeat (6) send_request(REQ_LOOKUP, mirror_keys[$urandom_range(0, mirror_count - 1)],
                                $urandom);
        steady = 1'b0;
        wait_drained();
    endtask

    // key from a shared pool so that hits, duplicates and a full table occur
    function automatic logic [KEY_W-1:0] pick_key();
        int r;
        r = $urandom_range(0, 99);
        if (r < 8) return KEY_W'($urandom);
        if (r < 40 && mirror_count > 0)
            return mirror_keys[$urandom_range(0, mirror_count - 1)];
        return key_pool[$urandom_range(0, POOL_SIZE - 1)];
    endfunction

    task automatic test_random_mix(input int n_items);
        bit               growing;
        int               r;
        logic [REQ_W-1:0] req;
        key_pool[0] = '0;
        key_pool[1] = KEY_TOP;
        for (int i = 2; i < POOL_SIZE; i++) key_pool[i] = KEY_W'($urandom);
        growing = 1'b1;
        for (int n = 0; n < n_items; n++) begin
            if (n % 100 == 0) steady = ($urandom_range(0, 3) == 0);
            // hysteresis keeps the table swinging between nearly empty and full
            if (mirror_count >= SKT_CAPACITY - 4) growing = 1'b0;
            if (mirror_count <= 4) growing = 1'b1;
            r = $urandom_range(0, 99);
            if (r < 8) begin
                req = REQ_W'($urandom_range(0, 3));   // noise
            end else if (r < 20) begin
                req = (r < 17) ? REQ_LOOKUP : REQ_SPARE;
            end else if (growing) begin
                req = (r < 80) ? REQ_INSERT : REQ_DELETE;
            end else begin
                req = (r < 80) ? REQ_DELETE : REQ_INSERT;
            end
            send_request(req, pick_key(), $urandom);
            // occasional pause until the block has caught up
            if ($urandom_range(0, 199) == 0) wait_drained();
        end
        steady = 1'b0;
        wait_drained();
    endtask

    // ------------------------------------------------------------------------
    // sequence
    // ------------------------------------------------------------------------
    initial begin
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = REQ_LOOKUP;
        mirror_count  = 0;
        n_fail        = 0;
        steady        = 1'b0;
        hold_cycles   = 0;
        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_directed();
        test_fill_and_empty();
        test_backpressure();
        test_random_mix(700);

        // let anything stray come out before the verdict
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (n_fail == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
